[hdl/sktm_pkg.sv]
// Package for the sorted key table: request/response structs, codes, FSM states.
// Used by sorted_key_table_merge_search and its testbench. No dependencies.
package sktm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = 40;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_MERGE = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_RUN = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic signed [31:0] key_value;
      logic signed [7:0] attr_code;
      logic [8:0] run_len;
   } req_type_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] index;
      logic signed [7:0] attr_out;
      logic [8:0] entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MRG_RD,
      S_MRG_WAIT,
      S_MRG_PICK,
      S_CPY_RD,
      S_CPY_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

endpackage

[hdl/sorted_key_table_merge_search.sv]
// Sorted key table with tail-run merge and binary search.
// Append writes one entry. Search reads and compares one probe at a time, at most 9 probes.
// Merge: entries are merged into the merge buffer, then copied back to the table,
// both through the single-port table and buffer RAMs.
// One transaction at a time; busy stays high through the strobe cycle, so the next
// transaction is taken after the result strobe. Synchronous reset clears count
// and control; RAMs are not cleared.
module sorted_key_table_merge_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sktm_pkg::req_type_type req_data,
   output logic                  rsp_strobe,
   output sktm_pkg::rsp_type     rsp_data
);
   localparam int AW = sktm_pkg::ADDR_W;
   localparam int CW = sktm_pkg::CNT_W;
   localparam int EW = sktm_pkg::ENTRY_W;

   sktm_pkg::state_type state_ff, state_in;
   sktm_pkg::req_type_type req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, split_ff, split_in;
   logic signed [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [EW-1:0] head_i_ff, head_i_in;
   sktm_pkg::rsp_type rsp_ff, rsp_in;
   logic strobe_ff, strobe_in;

   // table and merge buffer RAM ports
   logic tbl_we, buf_we;
   logic [AW-1:0] tbl_addr, buf_addr;
   logic [EW-1:0] tbl_wdata, buf_wdata, tbl_rdata, buf_rdata;
   logic signed [CW:0] mid, mid_inc, mid_dec;

   sktm_ram #(.WIDTH(EW), .DEPTH(sktm_pkg::TABLE_DEPTH)) u_tbl (
      .clock(clock), .we(tbl_we), .addr(tbl_addr), .wdata(tbl_wdata), .rdata(tbl_rdata));
   sktm_ram #(.WIDTH(EW), .DEPTH(sktm_pkg::TABLE_DEPTH)) u_buf (
      .clock(clock), .we(buf_we), .addr(buf_addr), .wdata(buf_wdata), .rdata(buf_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sktm_pkg::S_IDLE;
         count_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      split_ff <= split_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      head_i_ff <= head_i_in;
      rsp_ff <= rsp_in;
   end

   assign mid = (lo_ff + hi_ff) >>> 1;
   assign mid_inc = mid + (CW+1)'(1);
   assign mid_dec = mid - (CW+1)'(1);

   // sequencer
   always_comb begin
      logic take_i;
      logic signed [31:0] ki, kj;
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; split_in = split_ff;
      lo_in = lo_ff; hi_in = hi_ff;
      head_i_in = head_i_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      tbl_we = 1'b0; buf_we = 1'b0;
      tbl_addr = i_ff[AW-1:0]; buf_addr = k_ff[AW-1:0];
      tbl_wdata = {req_ff.key_value, req_ff.attr_code};
      buf_wdata = tbl_rdata;
      take_i = 1'b0;
      ki = head_i_ff[EW-1:8];
      kj = tbl_rdata[EW-1:8];
      unique case (state_ff)
         sktm_pkg::S_IDLE: begin
            if (start && !busy) begin
               req_in = req_data;
               rsp_in = '0;
               unique case (req_data.req_type)
                  sktm_pkg::REQ_APPEND: begin
                     if (count_ff == CW'(sktm_pkg::TABLE_DEPTH)) begin
                        rsp_in.status = sktm_pkg::ST_FULL;
                     end else begin
                        tbl_we = 1'b1;
                        tbl_addr = count_ff[AW-1:0];
                        tbl_wdata = {req_data.key_value, req_data.attr_code};
                        rsp_in.index = 8'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                     state_in = sktm_pkg::S_DONE;
                  end
                  sktm_pkg::REQ_MERGE: begin
                     if (req_data.run_len > 9'(count_ff)) begin
                        rsp_in.status = sktm_pkg::ST_BAD_RUN;
                        state_in = sktm_pkg::S_DONE;
                     end else begin
                        i_in = '0;
                        split_in = count_ff - CW'(req_data.run_len);
                        j_in = count_ff - CW'(req_data.run_len);
                        k_in = '0;
                        state_in = (count_ff == '0) ? sktm_pkg::S_DONE : sktm_pkg::S_MRG_RD;
                     end
                  end
                  sktm_pkg::REQ_SEARCH: begin
                     lo_in = '0;
                     hi_in = $signed({1'b0, count_ff} - 1'b1);
                     rsp_in.status = sktm_pkg::ST_NOT_FOUND;
                     state_in = (count_ff == '0) ? sktm_pkg::S_DONE : sktm_pkg::S_SRCH_RD;
                  end
                  default: state_in = sktm_pkg::S_DONE;
               endcase
            end
         end
         // fetch prefix head (i) into holding register
         sktm_pkg::S_MRG_RD: begin
            tbl_addr = i_ff[AW-1:0];
            state_in = sktm_pkg::S_MRG_WAIT;
         end
         // capture prefix head, then read tail head (j)
         sktm_pkg::S_MRG_WAIT: begin
            head_i_in = tbl_rdata;
            tbl_addr = j_ff[AW-1:0];
            state_in = sktm_pkg::S_MRG_PICK;
         end
         // pick one source and write the merge buffer
         sktm_pkg::S_MRG_PICK: begin
            if (i_ff < split_ff && j_ff < count_ff) take_i = (ki < kj);
            else take_i = !(j_ff < count_ff);
            buf_we = 1'b1;
            buf_addr = k_ff[AW-1:0];
            buf_wdata = take_i ? head_i_ff : tbl_rdata;
            if (take_i) i_in = i_ff + 1'b1;
            else j_in = j_ff + 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == count_ff) begin
               k_in = '0;
               state_in = sktm_pkg::S_CPY_RD;
            end else if (take_i) begin
               tbl_addr = i_in[AW-1:0];
               state_in = sktm_pkg::S_MRG_WAIT;
            end else begin
               tbl_addr = j_in[AW-1:0];
               state_in = sktm_pkg::S_MRG_PICK;
            end
         end
         sktm_pkg::S_CPY_RD: begin
            buf_addr = k_ff[AW-1:0];
            state_in = sktm_pkg::S_CPY_WR;
         end
         sktm_pkg::S_CPY_WR: begin
            tbl_we = 1'b1;
            tbl_addr = k_ff[AW-1:0];
            tbl_wdata = buf_rdata;
            k_in = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == count_ff) ? sktm_pkg::S_DONE : sktm_pkg::S_CPY_RD;
         end
         sktm_pkg::S_SRCH_RD: begin
            tbl_addr = mid[AW-1:0];
            state_in = sktm_pkg::S_SRCH_CMP;
         end
         sktm_pkg::S_SRCH_CMP: begin
            state_in = sktm_pkg::S_SRCH_RD;
            if (kj == req_ff.key_value) begin
               rsp_in.status = sktm_pkg::ST_OK;
               rsp_in.index = 8'(mid);
               rsp_in.attr_out = tbl_rdata[7:0];
               state_in = sktm_pkg::S_DONE;
            end else if (kj < req_ff.key_value) begin
               lo_in = mid_inc;
               if (mid_inc > hi_ff) state_in = sktm_pkg::S_DONE;
            end else begin
               hi_in = mid_dec;
               if (lo_ff > mid_dec) state_in = sktm_pkg::S_DONE;
            end
         end
         sktm_pkg::S_DONE: begin
            rsp_in.entry_count = 9'(count_ff);
            strobe_in = 1'b1;
            state_in = sktm_pkg::S_IDLE;
         end
         default: state_in = sktm_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != sktm_pkg::S_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   // count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sktm_pkg::TABLE_DEPTH)) else $error("count overflow");
   // a strobe follows only the done state
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == sktm_pkg::S_DONE) else $error("stray strobe");
   // count changes only after an append
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(req_data.req_type) == sktm_pkg::REQ_APPEND)
      else $error("count moved");
endmodule

[hdl/sktm_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sktm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

[tb/sv/tb_sorted_key_table_merge_search.sv]
// Testbench for sorted_key_table_merge_search: append, merge and search transactions
// checked against an in-bench table model. Depends on sktm_pkg and the block RTL.
module tb_sorted_key_table_merge_search;

   localparam int CYCLE_LIMIT = 2000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   sktm_pkg::req_type_type req_data = '0;
   logic                   rsp_strobe;
   sktm_pkg::rsp_type      rsp_data;

   sorted_key_table_merge_search dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // table model
   logic signed [31:0] tbl_key [sktm_pkg::TABLE_DEPTH];
   logic signed [7:0]  tbl_attr [sktm_pkg::TABLE_DEPTH];
   int unsigned        tbl_count = 0;

   sktm_pkg::rsp_type pending_rsp [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       burst_left = 0;

   // compute expected response and update model table
   function automatic sktm_pkg::rsp_type table_apply(sktm_pkg::req_type_type rq);
      sktm_pkg::rsp_type  r;
      logic signed [31:0] mk [sktm_pkg::TABLE_DEPTH];
      logic signed [7:0]  ma [sktm_pkg::TABLE_DEPTH];
      int                 lo, hi, mid, i, j, k, split;
      r = '0;
      case (rq.req_type)
         sktm_pkg::REQ_APPEND: begin
            if (tbl_count >= sktm_pkg::TABLE_DEPTH) begin
               r.status = sktm_pkg::ST_FULL;
            end else begin
               tbl_key[tbl_count] = rq.key_value;
               tbl_attr[tbl_count] = rq.attr_code;
               r.index = tbl_count[7:0];
               tbl_count++;
            end
         end
         sktm_pkg::REQ_MERGE: begin
            if (rq.run_len > tbl_count) begin
               r.status = sktm_pkg::ST_BAD_RUN;
            end else begin
               split = tbl_count - rq.run_len;
               i = 0; j = split;
               for (k = 0; k < tbl_count; k++) begin
                  if (i < split && j < tbl_count) begin
                     if (tbl_key[i] < tbl_key[j]) begin
                        mk[k] = tbl_key[i]; ma[k] = tbl_attr[i]; i++;
                     end else begin
                        mk[k] = tbl_key[j]; ma[k] = tbl_attr[j]; j++;
                     end
                  end else if (j < tbl_count) begin
                     mk[k] = tbl_key[j]; ma[k] = tbl_attr[j]; j++;
                  end else begin
                     mk[k] = tbl_key[i]; ma[k] = tbl_attr[i]; i++;
                  end
               end
               for (k = 0; k < tbl_count; k++) begin
                  tbl_key[k] = mk[k]; tbl_attr[k] = ma[k];
               end
            end
         end
         sktm_pkg::REQ_SEARCH: begin
            lo = 0; hi = int'(tbl_count) - 1;
            r.status = sktm_pkg::ST_NOT_FOUND;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (tbl_key[mid] == rq.key_value) begin
                  r.status = sktm_pkg::ST_OK;
                  r.index = mid[7:0];
                  r.attr_out = tbl_attr[mid];
                  break;
               end else if (tbl_key[mid] < rq.key_value) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = tbl_count[8:0];
      return r;
   endfunction

   // send one transaction; bursts with random gaps, start held between burst items
   task automatic send_req(input logic [1:0] op, input logic signed [31:0] key,
                           input logic signed [7:0] attr, input logic [8:0] run);
      sktm_pkg::rsp_type expected;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_data <= '{op, key, attr, run};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected = table_apply('{op, key, attr, run});
      pending_rsp.insert(pending_rsp.size(), expected);
      @(negedge clock);
   endtask

   // stop sending until every expected response is back
   task automatic drain_wait();
      start <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      sktm_pkg::rsp_type want;
      cycle_count++;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status || rsp_data.index !== want.index ||
                rsp_data.attr_out !== want.attr_out ||
                rsp_data.entry_count !== want.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_key();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 15)) - 32'd8;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // extremes, empty table, bad run, unused code, zero and full runs
   task automatic test_directed();
      send_req(sktm_pkg::REQ_SEARCH, 32'sd0, 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd1);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_APPEND, 32'sh7fffffff, 8'sh7f, 9'h1ff);
      send_req(sktm_pkg::REQ_APPEND, 32'sh80000000, 8'sh80, 9'd0);
      send_req(sktm_pkg::REQ_APPEND, 32'sd0, 8'sh55, 9'd0);
      send_req(sktm_pkg::REQ_APPEND, 32'sd0, 8'shaa, 9'd0);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd2);
      send_req(sktm_pkg::REQ_SEARCH, 32'sd0, 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_SEARCH, 32'sh80000000, 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_SEARCH, 32'sh7fffffff, 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd4);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd5);
      send_req(sktm_pkg::REQ_UNUSED, 32'sh5a5a5a5a, 8'sh33, 9'h155);
      send_req(sktm_pkg::REQ_SEARCH, 32'sh12345678, 8'shff, 9'h0aa);
   endtask

   // fill until full, hit the full case, then merge the whole table as a run
   task automatic test_full_table();
      while (tbl_count < sktm_pkg::TABLE_DEPTH)
         send_req(sktm_pkg::REQ_APPEND, rand_key(), 8'($urandom), 9'd0);
      send_req(sktm_pkg::REQ_APPEND, 32'sd1, 8'sd1, 9'd0);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd256);
      send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'd128);
      send_req(sktm_pkg::REQ_SEARCH, tbl_key[100], 8'sd0, 9'd0);
      send_req(sktm_pkg::REQ_SEARCH, 32'sh7fffffff, 8'sd0, 9'd0);
      drain_wait();
   endtask

   // random: appends, merges, searches of stored and random keys, unused code
   task automatic test_random();
      int n, s;
      for (n = 0; n < 200; n++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_req(sktm_pkg::REQ_APPEND, rand_key(), 8'($urandom), 9'($urandom));
            end
            2: send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0,
                        9'($urandom_range(0, tbl_count + 2)));
            3: send_req(sktm_pkg::REQ_UNUSED, $urandom, 8'($urandom), 9'($urandom));
            default: begin
               if (tbl_count > 0 && $urandom_range(0, 2) != 0) begin
                  s = $urandom_range(0, tbl_count - 1);
                  send_req(sktm_pkg::REQ_SEARCH, tbl_key[s], 8'($urandom), 9'($urandom));
               end else begin
                  send_req(sktm_pkg::REQ_SEARCH, rand_key(), 8'($urandom), 9'($urandom));
               end
            end
         endcase
         if (n == 100) drain_wait();
      end
   endtask

   // short ascending runs appended and merged into the table, then searched
   task automatic test_sorted_runs();
      int r, m, len;
      logic signed [31:0] v;
      for (r = 0; r < 6 && tbl_count < sktm_pkg::TABLE_DEPTH - 8; r++) begin
         len = $urandom_range(1, 8);
         v = $signed($urandom) >>> 4;
         for (m = 0; m < len; m++) begin
            send_req(sktm_pkg::REQ_APPEND, v, 8'($urandom), 9'd0);
            v = v + 32'($urandom_range(0, 3));
         end
         send_req(sktm_pkg::REQ_MERGE, 32'sd0, 8'sd0, 9'(len));
         send_req(sktm_pkg::REQ_SEARCH, v, 8'sd0, 9'd0);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_sorted_runs();
      drain_wait();
      test_random();
      test_full_table();
      drain_wait();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
